/* hw/rtl/gcb_pkg.sv */
package gcb_pkg;

  // Field widths of one transaction.
  localparam int ID_W      = 16;
  localparam int POS_W     = 32;
  localparam int INV_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = POS_W + INV_W;
  localparam int IP_W      = PROD_W - 2 * FRAC_W;
  localparam int CELL_ID_W = 15;
  localparam int SLOT_W    = 16;
  localparam int COUNT_W   = 17;
  localparam int GS_W      = 6;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE         = 1'b0,
    REG_INVERSE_CELL_SIZE = 1'b1
  } cfg_reg_t;

  localparam logic [GS_W-1:0]  GRID_SIZE_RST = 6'd32;
  localparam logic [INV_W-1:0] INV_CELL_RST  = 32'd65536;

  // Counter saturation limits.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] SLOT_MAX  = COUNT_W'({SLOT_W{1'b1}});

  // Default grid dimension per axis.
  localparam int GRID_MAX_DEF = 32;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/gcb_queue.sv */
module gcb_queue #(
  parameter int W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [W-1:0]        push_data,
  input  logic                pop,
  output logic [W-1:0]        head,
  output gcb_pkg::q_status_t  status
);

  localparam int DEPTH = gcb_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    entries [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] count;

  assign head         = entries[rptr];
  assign status.full  = (count == CNTW'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        entries[wptr] <= push_data;
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");

endmodule

/* hw/rtl/gcb_front.sv */
module gcb_front #(
  parameter int GRID_MAX = gcb_pkg::GRID_MAX_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [gcb_pkg::ID_W-1:0]               particle_id,
  input  logic signed [gcb_pkg::POS_W-1:0]       pos_x,
  input  logic signed [gcb_pkg::POS_W-1:0]       pos_y,
  input  logic signed [gcb_pkg::POS_W-1:0]       pos_z,
  input  logic [$clog2(GRID_MAX+1)-1:0]          grid_n,
  input  logic [gcb_pkg::INV_W-1:0]              inv,
  input  gcb_pkg::q_status_t                     q_status,
  output logic                                   busy,
  output logic                                   push,
  output logic [gcb_pkg::ID_W-1:0]               push_id,
  output logic [$clog2(GRID_MAX*GRID_MAX*GRID_MAX)-1:0] push_cell
);

  localparam int NW     = $clog2(GRID_MAX + 1);
  localparam int CW     = $clog2(GRID_MAX);
  localparam int TW     = $clog2(GRID_MAX * GRID_MAX);
  localparam int CELL_W = $clog2(GRID_MAX * GRID_MAX * GRID_MAX);
  localparam int POS_W  = gcb_pkg::POS_W;
  localparam int PROD_W = gcb_pkg::PROD_W;
  localparam int IP_W   = gcb_pkg::IP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_LIN1,
    S_LIN2,
    S_PUSH
  } state_t;

  state_t                    state;
  logic [1:0]                axis;
  logic [gcb_pkg::ID_W-1:0]  pid;
  logic signed [POS_W-1:0]   pos_a;
  logic signed [POS_W-1:0]   pos_b;
  logic signed [POS_W-1:0]   pos_c;
  logic [PROD_W-1:0]         prod;
  logic                      neg;
  logic [CW-1:0]             coord_x;
  logic [CW-1:0]             coord_y;
  logic [CW-1:0]             coord_z;
  logic [TW-1:0]             lin;
  logic [CELL_W-1:0]         cell_lin;

  logic [NW-1:0]             nm1;
  logic [IP_W-1:0]           ip;
  logic [CW-1:0]             coord_next;
  logic [PROD_W-1:0]         prod_next;

  // Any negative position lands in cell zero; otherwise the integer part
  // of the Q32.32 product is clamped to the last cell.
  always_comb begin
    nm1        = grid_n - 1'b1;
    ip         = prod[PROD_W-1:PROD_W-IP_W];
    prod_next  = PROD_W'(unsigned'(pos_a)) * PROD_W'(inv);
    if (neg) begin
      coord_next = '0;
    end else if (ip > IP_W'(nm1)) begin
      coord_next = CW'(nm1);
    end else begin
      coord_next = ip[CW-1:0];
    end
  end

  assign busy      = (state != S_IDLE);
  assign push      = (state == S_PUSH) && !q_status.full;
  assign push_id   = pid;
  assign push_cell = cell_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            pid   <= particle_id;
            pos_a <= pos_x;
            pos_b <= pos_y;
            pos_c <= pos_z;
            axis  <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod_next;
          neg   <= pos_a[POS_W-1];
          pos_a <= pos_b;
          pos_b <= pos_c;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          coord_z <= coord_next;
          coord_y <= coord_z;
          coord_x <= coord_y;
          axis    <= axis + 1'b1;
          state   <= (axis == 2'd2) ? S_LIN1 : S_MUL;
        end
        S_LIN1: begin
          lin   <= TW'(coord_z) * TW'(grid_n) + TW'(coord_y);
          state <= S_LIN2;
        end
        S_LIN2: begin
          cell_lin <= CELL_W'(lin) * CELL_W'(grid_n) + CELL_W'(coord_x);
          state    <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_status.full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_coords_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIN1) |->
      (NW'(coord_x) < grid_n && NW'(coord_y) < grid_n && NW'(coord_z) < grid_n))
    else $error("cell coordinate outside the grid");

endmodule

/* hw/rtl/gcb_back.sv */
module gcb_back #(
  parameter int GRID_MAX = gcb_pkg::GRID_MAX_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  gcb_pkg::q_status_t                            q_status,
  input  logic [gcb_pkg::ID_W-1:0]                      q_id,
  input  logic [$clog2(GRID_MAX*GRID_MAX*GRID_MAX)-1:0] q_cell,
  output logic                                          pop,
  output logic                                          clearing,
  output logic                                          done,
  output logic [gcb_pkg::ID_W-1:0]                      particle_out,
  output logic [gcb_pkg::CELL_ID_W-1:0]                 cell_id,
  output logic [gcb_pkg::SLOT_W-1:0]                    slot_in_cell
);

  localparam int CELL_TOTAL = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int CELL_W     = $clog2(CELL_TOTAL);
  localparam int COUNT_W    = gcb_pkg::COUNT_W;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_UPDATE
  } state_t;

  state_t                    state;
  logic [CELL_W-1:0]         clr_addr;
  logic [gcb_pkg::ID_W-1:0]  cur_id;
  logic [CELL_W-1:0]         cur_cell;

  logic [COUNT_W-1:0]        cell_counts [CELL_TOTAL];
  logic [COUNT_W-1:0]        rdata;
  logic                      mem_we;
  logic [CELL_W-1:0]         mem_waddr;
  logic [COUNT_W-1:0]        mem_wdata;
  logic [COUNT_W-1:0]        count_inc;

  assign clearing  = (state == B_CLEAR);
  assign pop       = (state == B_IDLE) && !q_status.empty;
  assign count_inc = (rdata == gcb_pkg::COUNT_MAX) ? rdata : rdata + 1'b1;
  assign mem_we    = clearing || (state == B_UPDATE);
  assign mem_waddr = clearing ? clr_addr : cur_cell;
  assign mem_wdata = clearing ? '0 : count_inc;

  // The read is issued as the entry leaves the queue; the data is back
  // for the update cycle, and the write lands before the next read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_counts[mem_waddr] <= mem_wdata;
    end
    rdata <= cell_counts[q_cell];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CELL_W'(CELL_TOTAL - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_status.empty) begin
            cur_id   <= q_id;
            cur_cell <= q_cell;
            state    <= B_UPDATE;
          end
        end
        B_UPDATE: begin
          particle_out <= cur_id;
          cell_id      <= gcb_pkg::CELL_ID_W'(cur_cell);
          slot_in_cell <= (rdata > gcb_pkg::SLOT_MAX) ? '1 : rdata[gcb_pkg::SLOT_W-1:0];
          done         <= 1'b1;
          state        <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done)
    else $error("result strobe during the clearing pass");

  a_single_cycle_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes in consecutive cycles");

endmodule

/* hw/rtl/grid_cell_binning_counter.sv */
// Counting-sort histogram stage for a uniform 3-D grid. Each transaction
// accepted on start (taken at a rising edge where start is high and busy is
// low) carries a particle index and a signed Q16.16 position; the block
// scales each axis by inverse_cell_size, clamps the integer part into the
// grid, linearizes the cell as x + y*n + z*n*n and returns the cell index
// with the cell's previous count as the particle's slot. A new transaction
// can start once the front part has pushed the previous one into the queue:
// per axis it uses a single shared 32x32 multiplier and clamps, then
// linearizes the index and pushes it, waiting while the queue is full, and
// busy stays high meanwhile. The back part then reads and updates the cell
// and marks the result by done for exactly one cycle; there is no back-pressure,
// so the receiver must capture it in that cycle. After reset the count memory
// (GRID_MAX^3 entries, 32768 at the default size) is cleared one entry per
// cycle, and busy stays high until it is clear. Configuration writes are taken at
// any time but must only be issued while no transaction is in flight.
module grid_cell_binning_counter #(
  parameter int GRID_MAX = gcb_pkg::GRID_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [gcb_pkg::ID_W-1:0]            particle_id,
  input  logic signed [gcb_pkg::POS_W-1:0]    pos_x,
  input  logic signed [gcb_pkg::POS_W-1:0]    pos_y,
  input  logic signed [gcb_pkg::POS_W-1:0]    pos_z,
  output logic                                done,
  output logic [gcb_pkg::ID_W-1:0]            particle_out,
  output logic [gcb_pkg::CELL_ID_W-1:0]       cell_id,
  output logic [gcb_pkg::SLOT_W-1:0]          slot_in_cell,
  input  logic                                cfg_write,
  input  logic [gcb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gcb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int NW     = $clog2(GRID_MAX + 1);
  localparam int CELL_W = $clog2(GRID_MAX * GRID_MAX * GRID_MAX);
  localparam int ENTRY_W = gcb_pkg::ID_W + CELL_W;

  // Configuration registers.
  logic [gcb_pkg::GS_W-1:0]  grid_size;
  logic [gcb_pkg::INV_W-1:0] inverse_cell_size;

  // Effective cells per axis: a size of zero acts as one, and anything above
  // the built-in grid dimension is held at that dimension.
  logic [NW-1:0] grid_n;

  logic               front_busy;
  logic               push;
  logic [gcb_pkg::ID_W-1:0] push_id;
  logic [CELL_W-1:0]  push_cell;
  logic [ENTRY_W-1:0] head;
  logic               pop;
  logic               clearing;
  gcb_pkg::q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size         <= gcb_pkg::GRID_SIZE_RST;
      inverse_cell_size <= gcb_pkg::INV_CELL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        gcb_pkg::REG_GRID_SIZE: begin
          grid_size <= cfg_data[gcb_pkg::GS_W-1:0];
        end
        gcb_pkg::REG_INVERSE_CELL_SIZE: begin
          inverse_cell_size <= cfg_data[gcb_pkg::INV_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_size == '0) begin
      grid_n = NW'(1);
    end else if (32'(grid_size) > GRID_MAX) begin
      grid_n = NW'(GRID_MAX);
    end else begin
      grid_n = NW'(grid_size);
    end
  end

  // The front part is the only place that takes new work, and nothing is
  // taken while the count memory is still being cleared.
  assign busy = front_busy || clearing;

  gcb_front #(
    .GRID_MAX (GRID_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !clearing),
    .particle_id (particle_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .grid_n      (grid_n),
    .inv         (inverse_cell_size),
    .q_status    (q_status),
    .busy        (front_busy),
    .push        (push),
    .push_id     (push_id),
    .push_cell   (push_cell)
  );

  // A short queue between the two parts lets the front part finish its
  // arithmetic while the back part is still updating an earlier cell.
  gcb_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_id, push_cell}),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The back part owns the count memory: it clears it after reset, then
  // performs one read, increment and write per transaction.
  gcb_back #(
    .GRID_MAX (GRID_MAX)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_id         (head[ENTRY_W-1:CELL_W]),
    .q_cell       (head[CELL_W-1:0]),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .particle_out (particle_out),
    .cell_id      (cell_id),
    .slot_in_cell (slot_in_cell)
  );

endmodule
